// ----- design/pixel_hit_merge_table_core_macros.svh -----
// ----------------------------------------------------------------------------
// pixel hit merge table assertion macros
// shared concurrent assertion wrappers, removed when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef PIXEL_HIT_MERGE_TABLE_CORE_MACROS_SVH
`define PIXEL_HIT_MERGE_TABLE_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// property checked outside reset
`define PHMT_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("phmt assertion failed");
// property checked at every edge, reset included
`define PHMT_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("phmt assertion failed");
`else
`define PHMT_ASSERT(lbl, clk, rstn, prop)
`define PHMT_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- design/phmt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel hit merge table package
// shared widths, item types and sequencer states
// ----------------------------------------------------------------------------
package phmt_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int POS_W    = 30;
    localparam int ENERGY_W = 24;
    localparam int EVENT_W  = 32;
    localparam int CODE_W   = 32;
    localparam int SLOT_W   = 8;
    localparam int IN_DATA_W  = 120;
    localparam int OUT_DATA_W = 8;
    localparam int OUT_USER_W = 3;
    localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;

    // one hit as held in the queue
    typedef struct packed {
        logic [POS_W-1:0]    pos;
        logic [ENERGY_W-1:0] energy;
        logic [EVENT_W-1:0]  event_no;
        logic [CODE_W-1:0]   code;
        logic                sec;
    } t_item;

    // queue head seen by the engine
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_head;

    // one result item
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              merged;
        logic              full;
        logic              sat;
    } t_result;

    // engine sequencer
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD   = 4'b0010,
        S_CMP  = 4'b0100,
        S_APP  = 4'b1000
    } t_state;

endpackage

// ----- design/phmt_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel hit merge table front end
// accepts hit items, unpacks the stream word and queues them for the engine
// ----------------------------------------------------------------------------
`include "pixel_hit_merge_table_core_macros.svh"
module phmt_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [phmt_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic                           s_tuser,
    output phmt_pkg::t_head                o_head,
    input  logic                           i_pop
);
    import phmt_pkg::*;

    t_item      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_item      w_in;
    logic       w_push;

    // unpack: column, row, layer, energy, event, code
    always_comb begin
        w_in.pos      = {s_tdata[11:0], s_tdata[23:12], s_tdata[29:24]};
        w_in.energy   = s_tdata[53:30];
        w_in.event_no = s_tdata[85:54];
        w_in.code     = s_tdata[117:86];
        w_in.sec      = s_tuser;
    end

    assign s_tready = (r_cnt != 2'd2);
    assign w_push   = s_tvalid && s_tready;

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_in;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_pop};
        end
    end

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.item  = r_q[r_rp];

    `PHMT_ASSERT(a_cnt_max, i_clk, i_rst_n, r_cnt != 2'd3)
    `PHMT_ASSERT(a_pop_nonempty, i_clk, i_rst_n, i_pop |-> r_cnt != 2'd0)
    `PHMT_ASSERT(a_ptr_gap, i_clk, i_rst_n,
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> r_wp == r_rp)
endmodule

// ----- design/phmt_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel hit merge table engine
// scans stored entries for a match, merges, appends or flags a full table, registers the result
// ----------------------------------------------------------------------------
`include "pixel_hit_merge_table_core_macros.svh"
module phmt_engine #(
    parameter int TABLE_DEPTH = phmt_pkg::TABLE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_data,
    input  phmt_pkg::t_head   i_head,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output phmt_pkg::t_result o_res
);
    import phmt_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int DW = ENERGY_W + EVENT_W + CODE_W + 1;

    t_state          r_state, n_state;
    logic            r_merge_en;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_addr, n_addr;
    t_item           r_item;
    logic            r_out_valid, n_out_valid;
    t_result         r_res, n_res;

    // table memories
    logic [POS_W-1:0] r_pos_mem [TABLE_DEPTH];
    logic [DW-1:0]    r_dat_mem [TABLE_DEPTH];
    logic [POS_W-1:0] r_pos_q;
    logic [DW-1:0]    r_dat_q;
    logic             w_pos_we, w_dat_we;
    logic [AW-1:0]    w_waddr;
    logic [DW-1:0]    w_wdat;

    logic [ENERGY_W:0]   w_sum;
    logic [ENERGY_W-1:0] q_energy;
    logic [EVENT_W-1:0]  q_event;
    logic [CODE_W-1:0]   q_code;
    logic                q_sec;
    logic                w_out_busy;

    assign {q_energy, q_event, q_code, q_sec} = r_dat_q;
    assign w_sum = {1'b0, q_energy} + {1'b0, r_item.energy};
    assign w_out_busy = r_out_valid && !i_ready;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_merge_en <= 1'b1;
        end else if (i_cfg_we) begin
            r_merge_en <= i_cfg_data;
        end
    end

    // sequencer next state
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_addr      = r_addr;
        n_out_valid = r_out_valid && !i_ready;
        n_res       = r_res;
        o_pop       = 1'b0;
        w_pos_we    = 1'b0;
        w_dat_we    = 1'b0;
        w_waddr     = r_addr;
        w_wdat      = r_dat_q;
        unique case (r_state)
            S_IDLE: begin
                if (i_head.valid && !w_out_busy) begin
                    o_pop  = 1'b1;
                    n_addr = '0;
                    n_state = (r_merge_en && r_count != '0) ? S_RD : S_APP;
                end
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (r_pos_q == r_item.pos) begin
                    // merge into this entry
                    w_dat_we = 1'b1;
                    w_wdat[DW-1 -: ENERGY_W] = w_sum[ENERGY_W] ? ENERGY_MAX
                                                               : w_sum[ENERGY_W-1:0];
                    w_wdat[1 + CODE_W +: EVENT_W] =
                        ($signed(q_code) < $signed(r_item.code)) ? r_item.event_no
                                                                 : q_event;
                    w_wdat[0]   = q_sec & r_item.sec;
                    n_res.slot   = SLOT_W'(r_addr);
                    n_res.merged = 1'b1;
                    n_res.full   = 1'b0;
                    n_res.sat    = w_sum[ENERGY_W];
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end else if ((CW'(r_addr) + CW'(1)) == r_count) begin
                    n_state = S_APP;
                end else begin
                    n_addr  = r_addr + AW'(1);
                    n_state = S_RD;
                end
            end
            S_APP: begin
                n_res.merged = 1'b0;
                n_res.sat    = 1'b0;
                n_out_valid  = 1'b1;
                n_state      = S_IDLE;
                if (r_count == CW'(TABLE_DEPTH)) begin
                    n_res.slot = '0;
                    n_res.full = 1'b1;
                end else begin
                    w_pos_we   = 1'b1;
                    w_dat_we   = 1'b1;
                    w_waddr    = r_count[AW-1:0];
                    w_wdat     = {r_item.energy, r_item.event_no, r_item.code, r_item.sec};
                    n_res.slot = SLOT_W'(r_count[AW-1:0]);
                    n_res.full = 1'b0;
                    n_count    = r_count + CW'(1);
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_res  <= n_res;
        if (o_pop) r_item <= i_head.item;
    end

    // memory write and registered read
    always_ff @(posedge i_clk) begin
        if (w_pos_we) r_pos_mem[w_waddr] <= r_item.pos;
        if (w_dat_we) r_dat_mem[w_waddr] <= w_wdat;
        r_pos_q <= r_pos_mem[r_addr];
        r_dat_q <= r_dat_mem[r_addr];
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_res;

    `PHMT_ASSERT(a_count_max, i_clk, i_rst_n, r_count <= CW'(TABLE_DEPTH))
    `PHMT_ASSERT(a_res_source, i_clk, i_rst_n,
        $rose(r_out_valid) |-> ($past(r_state) == S_CMP || $past(r_state) == S_APP))
    `PHMT_ASSERT(a_full_only_at_cap, i_clk, i_rst_n,
        (r_out_valid && r_res.full) |-> (r_count == CW'(TABLE_DEPTH) && !r_res.merged))
    `PHMT_ASSERT(a_no_pop_when_busy, i_clk, i_rst_n, o_pop |-> !w_out_busy)
endmodule

// ----- design/pixel_hit_merge_table_core.sv -----
`timescale 1ns / 1ps
// a hit leaves the queue head in the idle state, then each entry scanned takes a read and
// a compare state (none with merging off or an empty table); a match merges from the
// compare state into the result register, else the append state appends the hit or flags a full table
// throughput: one hit at a time; the next hit leaves the queue only once the result
// register is empty or being taken
// reset: synchronous active low; empties the queue and the table, merging enabled
// ----------------------------------------------------------------------------
// pixel hit merge table
// merges pixel hits on the same pixel and layer into a table of entries
// ----------------------------------------------------------------------------
module pixel_hit_merge_table_core #(
    parameter int TABLE_DEPTH = phmt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // column, row, layer, energy, event, particle code, zero pad
    input  logic [phmt_pkg::IN_DATA_W-1:0]  s_tdata,
    // is_secondary
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // entry_slot
    output logic [phmt_pkg::OUT_DATA_W-1:0] m_tdata,
    // was_merged, table_full, energy_saturated
    output logic [phmt_pkg::OUT_USER_W-1:0] m_tuser
);
    import phmt_pkg::*;

    t_head   w_head;
    logic    w_pop;
    t_result w_res;

    phmt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .o_head   (w_head),
        .i_pop    (w_pop)
    );

    phmt_engine #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_head     (w_head),
        .o_pop      (w_pop),
        .o_valid    (m_tvalid),
        .i_ready    (m_tready),
        .o_res      (w_res)
    );

    assign m_tdata = w_res.slot;
    assign m_tuser = {w_res.sat, w_res.full, w_res.merged};
endmodule
